// ----- rtl/mobt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack object boundary tracker: shared package
// Sizes, type codes, header decode classes and the nesting stack request
// and response types used across the tracker.
// ----------------------------------------------------------------------------
package mobt_pkg;

  // Sizing.
  localparam int unsigned MAX_DEPTH   = 16;
  localparam int unsigned LENGTH_BITS = 32;
  localparam int unsigned LEN_W       = LENGTH_BITS;
  localparam int unsigned CNT_W       = LEN_W + 1;
  localparam int unsigned DEPTH_W     = $clog2(MAX_DEPTH + 1);
  localparam int unsigned IDX_W       = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int unsigned OUT_LEN_W   = 32;
  localparam int unsigned NEST_W      = 5;
  localparam int unsigned SMALL_N_W   = 5;

  // Header byte boundaries of the format.
  localparam logic [7:0] HB_POSFIX_MAX = 8'h7f;
  localparam logic [7:0] HB_NEGFIX_MIN = 8'he0;
  localparam logic [7:0] HB_FIXMAP_MAX = 8'h8f;
  localparam logic [7:0] HB_FIXARR_MAX = 8'h9f;
  localparam logic [7:0] HB_FIXSTR_MAX = 8'hbf;
  localparam logic [7:0] HB_NIL        = 8'hc0;
  localparam logic [7:0] HB_RESERVED   = 8'hc1;
  localparam logic [7:0] HB_FALSE      = 8'hc2;
  localparam logic [7:0] HB_TRUE       = 8'hc3;
  localparam logic [7:0] HB_BIN_LO     = 8'hc4;
  localparam logic [7:0] HB_BIN_HI     = 8'hc6;
  localparam logic [7:0] HB_EXT_LO     = 8'hc7;
  localparam logic [7:0] HB_EXT_HI     = 8'hc9;
  localparam logic [7:0] HB_FLOAT32    = 8'hca;
  localparam logic [7:0] HB_FLOAT64    = 8'hcb;
  localparam logic [7:0] HB_UINT_LO    = 8'hcc;
  localparam logic [7:0] HB_UINT_HI    = 8'hcf;
  localparam logic [7:0] HB_INT_LO     = 8'hd0;
  localparam logic [7:0] HB_INT_HI     = 8'hd3;
  localparam logic [7:0] HB_FIXEXT_LO  = 8'hd4;
  localparam logic [7:0] HB_FIXEXT_HI  = 8'hd8;
  localparam logic [7:0] HB_STR_LO     = 8'hd9;
  localparam logic [7:0] HB_STR_HI     = 8'hdb;
  localparam logic [7:0] HB_ARR_LO     = 8'hdc;
  localparam logic [7:0] HB_ARR_HI     = 8'hdd;
  localparam logic [7:0] HB_MAP_LO     = 8'hde;

  // Byte roles, also the parser phase codes.
  localparam logic [1:0] ROLE_HEADER   = 2'd0;
  localparam logic [1:0] ROLE_LENGTH   = 2'd1;
  localparam logic [1:0] ROLE_EXT_TYPE = 2'd2;
  localparam logic [1:0] ROLE_PAYLOAD  = 2'd3;

  typedef enum logic [3:0] {
    KIND_FALSE  = 4'd0,
    KIND_TRUE   = 4'd1,
    KIND_UINT   = 4'd2,
    KIND_INT    = 4'd3,
    KIND_BIN    = 4'd4,
    KIND_STR    = 4'd5,
    KIND_FLOAT  = 4'd6,
    KIND_EXT    = 4'd7,
    KIND_ARRAY  = 4'd8,
    KIND_MAP    = 4'd9,
    KIND_NIL    = 4'd10,
    KIND_UNUSED = 4'd11
  } kind_e;

  // What a header byte asks the parser to do next.
  typedef enum logic [2:0] {
    ACT_IMMEDIATE,
    ACT_CONTAINER,
    ACT_FIXED,
    ACT_NEED_LEN,
    ACT_FIXEXT,
    ACT_RESERVED
  } hdr_act_e;

  typedef struct packed {
    kind_e                 kind;
    hdr_act_e              act;
    logic [SMALL_N_W-1:0]  n;
  } hdr_info_t;

  typedef enum logic [1:0] {
    NEST_NOP,
    NEST_COMPLETE,
    NEST_OPEN,
    NEST_CLEAR
  } nest_op_e;

  typedef struct packed {
    nest_op_e          op;
    logic [CNT_W-1:0]  count;
  } nest_req_t;

  typedef struct packed {
    logic                top_end;
    logic                overflow;
    logic [DEPTH_W-1:0]  depth_next;
  } nest_rsp_t;

endpackage

// ----- rtl/mobt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack tracker channels
// Valid/ready channels for incoming stream words and outgoing result words.
// ----------------------------------------------------------------------------
interface mobt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface mobt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [3:0]  value_type;
  logic [31:0] object_length;
  logic        header_done;
  logic        object_end;
  logic [4:0]  nest_depth;
  logic        error_flag;

  modport source (output valid, output byte_role, output value_type, output object_length,
                  output header_done, output object_end, output nest_depth,
                  output error_flag, input ready);
  modport sink (input valid, input byte_role, input value_type, input object_length,
                input header_done, input object_end, input nest_depth,
                input error_flag, output ready);
endinterface

// ----- rtl/msgpack_object_boundary_tracker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack object boundary tracker
// Parses a MessagePack stream one byte per word, reporting each byte's role,
// the object type and length once a header is complete, the nesting depth and
// the end of every top-level object.
//
//   Port   Dir  Word                      Handshake
//   in_i   in   stream_byte (8 bits)      valid/ready
//   out_o  out  role, type, length,       valid/ready
//               header_done, end, depth,
//               error_flag
//
// One byte is taken every cycle unless the output stalls; each result passes
// the input and then the result register. The parse step, including closing
// any number of nested levels, is one pass through the header decoder and the
// nesting stack's priority encoder. Reset clears the parser state and the
// stack pointer; the count storage is not cleared. A stalled output holds its
// word and the input register fills behind it before ready drops.
// ----------------------------------------------------------------------------
module msgpack_object_boundary_tracker import mobt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mobt_in_if.sink   in_i,
  mobt_out_if.source out_o
);

  // Parser phases share their codes with the byte roles.
  localparam logic [1:0] PH_HEAD = ROLE_HEADER;
  localparam logic [1:0] PH_LEN  = ROLE_LENGTH;
  localparam logic [1:0] PH_EXT  = ROLE_EXT_TYPE;
  localparam logic [1:0] PH_PAY  = ROLE_PAYLOAD;

  logic             in_valid_q;
  logic [7:0]       byte_q;
  logic             out_valid_q;
  logic             advance;
  logic             step;

  logic [1:0]       phase_q, phase_d;
  kind_e            kind_q, kind_d;
  logic [LEN_W-1:0] acc_q, acc_d;
  logic [2:0]       left_q, left_d;
  logic [LEN_W-1:0] pay_q, pay_d;

  hdr_info_t        info;
  nest_req_t        nreq;
  nest_rsp_t        nrsp;

  logic             hdr_done;
  logic [LEN_W-1:0] hdr_len;
  logic             res_err;
  logic [LEN_W-1:0] acc_shift;
  logic [2:0]       left_dec;
  logic [LEN_W-1:0] pay_dec;

  logic [1:0]           role_q;
  kind_e                type_q;
  logic [OUT_LEN_W-1:0] len_q;
  logic                 done_q;
  logic                 end_q;
  logic [NEST_W-1:0]    depth_q;
  logic                 err_q;

  // Flow control: a byte moves on when the result register is free.
  assign advance    = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      byte_q <= in_i.stream_byte;
    end
  end

  mobt_hdr_dec u_hdr_dec (
    .hdr_byte_i (byte_q),
    .info_o     (info)
  );

  mobt_nest_stack u_nest (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  assign acc_shift = LEN_W'({acc_q, byte_q});
  assign left_dec  = (left_q != '0) ? left_q - 3'd1 : '0;
  assign pay_dec   = (pay_q != '0) ? pay_q - LEN_W'(1) : '0;

  // Parse step for the byte in the input register.
  always_comb begin
    phase_d    = phase_q;
    kind_d     = kind_q;
    acc_d      = acc_q;
    left_d     = left_q;
    pay_d      = pay_q;
    nreq.op    = NEST_NOP;
    nreq.count = '0;
    hdr_done   = 1'b0;
    hdr_len    = '0;
    res_err    = 1'b0;
    case (phase_q)
      PH_HEAD: begin
        kind_d = info.kind;
        case (info.act)
          ACT_IMMEDIATE: begin
            hdr_done = 1'b1;
            hdr_len  = LEN_W'(1);
            nreq.op  = NEST_COMPLETE;
          end
          ACT_CONTAINER: begin
            hdr_done   = 1'b1;
            hdr_len    = LEN_W'(info.n);
            nreq.op    = NEST_OPEN;
            nreq.count = (info.kind == KIND_MAP) ? CNT_W'({info.n, 1'b0})
                                                 : CNT_W'(info.n);
          end
          ACT_FIXED: begin
            hdr_done = 1'b1;
            hdr_len  = LEN_W'(info.n);
            if (info.n == '0) begin
              nreq.op = NEST_COMPLETE;
            end else begin
              pay_d   = LEN_W'(info.n);
              phase_d = PH_PAY;
            end
          end
          ACT_NEED_LEN: begin
            acc_d   = '0;
            left_d  = 3'(info.n);
            phase_d = PH_LEN;
          end
          ACT_FIXEXT: begin
            acc_d   = LEN_W'(info.n);
            phase_d = PH_EXT;
          end
          ACT_RESERVED: begin
            res_err = 1'b1;
            nreq.op = NEST_CLEAR;
          end
          default: begin
            phase_d = PH_HEAD;
          end
        endcase
      end
      PH_LEN: begin
        acc_d  = acc_shift;
        left_d = left_dec;
        if (left_dec == '0) begin
          // Length field complete.
          if (kind_q == KIND_EXT) begin
            phase_d = PH_EXT;
          end else if (kind_q == KIND_ARRAY || kind_q == KIND_MAP) begin
            hdr_done   = 1'b1;
            hdr_len    = acc_shift;
            phase_d    = PH_HEAD;
            nreq.op    = NEST_OPEN;
            nreq.count = (kind_q == KIND_MAP) ? CNT_W'({acc_shift, 1'b0})
                                              : CNT_W'(acc_shift);
          end else begin
            hdr_done = 1'b1;
            hdr_len  = acc_shift;
            if (acc_shift == '0) begin
              phase_d = PH_HEAD;
              nreq.op = NEST_COMPLETE;
            end else begin
              pay_d   = acc_shift;
              phase_d = PH_PAY;
            end
          end
        end
      end
      PH_EXT: begin
        hdr_done = 1'b1;
        hdr_len  = acc_q;
        if (acc_q == '0) begin
          phase_d = PH_HEAD;
          nreq.op = NEST_COMPLETE;
        end else begin
          pay_d   = acc_q;
          phase_d = PH_PAY;
        end
      end
      default: begin
        pay_d = pay_dec;
        if (pay_dec == '0) begin
          phase_d = PH_HEAD;
          nreq.op = NEST_COMPLETE;
        end
      end
    endcase
  end

  // Parser state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      kind_q  <= KIND_FALSE;
      acc_q   <= '0;
      left_q  <= '0;
      pay_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      pay_q   <= pay_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      role_q  <= phase_q;
      type_q  <= kind_d;
      len_q   <= hdr_done ? OUT_LEN_W'(hdr_len) : '0;
      done_q  <= hdr_done;
      end_q   <= nrsp.top_end;
      depth_q <= NEST_W'(nrsp.depth_next);
      err_q   <= res_err || nrsp.overflow;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.byte_role     = role_q;
  assign out_o.value_type    = type_q;
  assign out_o.object_length = len_q;
  assign out_o.header_done   = done_q;
  assign out_o.object_end    = end_q;
  assign out_o.nest_depth    = depth_q;
  assign out_o.error_flag    = err_q;

  // Any error leaves the nesting cleared.
  a_err_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.error_flag |-> out_o.nest_depth == '0)
    else $error("error result with open nesting");

  // A top-level end can only be reported at depth zero.
  a_end_at_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.object_end |-> out_o.nest_depth == '0)
    else $error("object end reported inside a container");

  // The depth never goes past the stack size.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.nest_depth <= NEST_W'(MAX_DEPTH))
    else $error("nesting depth beyond stack size");

  // A byte held in the input register waits unchanged while the output stalls.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(byte_q))
    else $error("buffered byte lost during output stall");

endmodule

// ----- rtl/mobt_hdr_dec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack header decoder
// Classifies a header byte into its object kind, the follow-up action and a
// small embedded number (fix length, element count or length byte count).
// ----------------------------------------------------------------------------
module mobt_hdr_dec import mobt_pkg::*; (
  input  logic [7:0] hdr_byte_i,
  output hdr_info_t  info_o
);

  logic [7:0] b;

  assign b = hdr_byte_i;

  // Range decode of the header byte.
  always_comb begin
    info_o.kind = KIND_UINT;
    info_o.act  = ACT_IMMEDIATE;
    info_o.n    = '0;
    if (b <= HB_POSFIX_MAX) begin
      info_o.kind = KIND_UINT;
    end else if (b >= HB_NEGFIX_MIN) begin
      info_o.kind = KIND_INT;
    end else if (b <= HB_FIXMAP_MAX) begin
      info_o.kind = KIND_MAP;
      info_o.act  = ACT_CONTAINER;
      info_o.n    = SMALL_N_W'(b[3:0]);
    end else if (b <= HB_FIXARR_MAX) begin
      info_o.kind = KIND_ARRAY;
      info_o.act  = ACT_CONTAINER;
      info_o.n    = SMALL_N_W'(b[3:0]);
    end else if (b <= HB_FIXSTR_MAX) begin
      info_o.kind = KIND_STR;
      info_o.act  = ACT_FIXED;
      info_o.n    = SMALL_N_W'(b[4:0]);
    end else if (b == HB_NIL) begin
      info_o.kind = KIND_NIL;
    end else if (b == HB_RESERVED) begin
      info_o.kind = KIND_UNUSED;
      info_o.act  = ACT_RESERVED;
    end else if (b == HB_FALSE) begin
      info_o.kind = KIND_FALSE;
    end else if (b == HB_TRUE) begin
      info_o.kind = KIND_TRUE;
    end else if (b <= HB_BIN_HI) begin
      info_o.kind = KIND_BIN;
      info_o.act  = ACT_NEED_LEN;
      info_o.n    = SMALL_N_W'(1) << 2'(b - HB_BIN_LO);
    end else if (b <= HB_EXT_HI) begin
      info_o.kind = KIND_EXT;
      info_o.act  = ACT_NEED_LEN;
      info_o.n    = SMALL_N_W'(1) << 2'(b - HB_EXT_LO);
    end else if (b == HB_FLOAT32) begin
      info_o.kind = KIND_FLOAT;
      info_o.act  = ACT_FIXED;
      info_o.n    = SMALL_N_W'(4);
    end else if (b == HB_FLOAT64) begin
      info_o.kind = KIND_FLOAT;
      info_o.act  = ACT_FIXED;
      info_o.n    = SMALL_N_W'(8);
    end else if (b <= HB_UINT_HI) begin
      info_o.kind = KIND_UINT;
      info_o.act  = ACT_FIXED;
      info_o.n    = SMALL_N_W'(1) << 2'(b - HB_UINT_LO);
    end else if (b <= HB_INT_HI) begin
      info_o.kind = KIND_INT;
      info_o.act  = ACT_FIXED;
      info_o.n    = SMALL_N_W'(1) << 2'(b - HB_INT_LO);
    end else if (b <= HB_FIXEXT_HI) begin
      info_o.kind = KIND_EXT;
      info_o.act  = ACT_FIXEXT;
      info_o.n    = SMALL_N_W'(1) << 3'(b - HB_FIXEXT_LO);
    end else if (b <= HB_STR_HI) begin
      info_o.kind = KIND_STR;
      info_o.act  = ACT_NEED_LEN;
      info_o.n    = SMALL_N_W'(1) << 2'(b - HB_STR_LO);
    end else if (b <= HB_ARR_HI) begin
      info_o.kind = KIND_ARRAY;
      info_o.act  = ACT_NEED_LEN;
      info_o.n    = SMALL_N_W'(2) << 1'(b - HB_ARR_LO);
    end else begin
      info_o.kind = KIND_MAP;
      info_o.act  = ACT_NEED_LEN;
      info_o.n    = SMALL_N_W'(2) << 1'(b - HB_MAP_LO);
    end
  end

endmodule

// ----- rtl/mobt_nest_stack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MessagePack nesting stack
// Holds the element counts still owed by open arrays and maps. An element end
// closes every level whose last element it is in one step, found by a
// priority encoder over per-level last-element bits.
// ----------------------------------------------------------------------------
module mobt_nest_stack import mobt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  nest_req_t  req_i,
  output nest_rsp_t  rsp_o
);

  logic [CNT_W-1:0]   cnt_q [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] last_q;
  logic [DEPTH_W-1:0] sp_q, sp_d;

  logic [MAX_DEPTH-1:0] live;
  logic                 found;
  logic [IDX_W-1:0]     top_idx;
  logic [CNT_W-1:0]     top_cnt;

  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [CNT_W-1:0]     wr_val;
  logic                 wr_last;
  logic                 do_complete;

  // Highest open level that is not on its last element.
  always_comb begin
    found   = 1'b0;
    top_idx = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      live[i] = (DEPTH_W'(i) < sp_q) && !last_q[i];
      if (live[i]) begin
        found   = 1'b1;
        top_idx = IDX_W'(i);
      end
    end
  end

  assign top_cnt = cnt_q[top_idx];

  // Request handling: element end, container open or clear.
  always_comb begin
    sp_d                = sp_q;
    wr_en               = 1'b0;
    wr_idx              = top_idx;
    wr_val              = top_cnt - CNT_W'(1);
    wr_last             = (top_cnt == CNT_W'(2));
    do_complete         = 1'b0;
    rsp_o.top_end       = 1'b0;
    rsp_o.overflow      = 1'b0;
    case (req_i.op)
      NEST_COMPLETE: begin
        do_complete = 1'b1;
      end
      NEST_OPEN: begin
        if (req_i.count == '0) begin
          do_complete = 1'b1;
        end else if (sp_q >= DEPTH_W'(MAX_DEPTH)) begin
          rsp_o.overflow = 1'b1;
          sp_d           = '0;
        end else begin
          wr_en   = 1'b1;
          wr_idx  = sp_q[IDX_W-1:0];
          wr_val  = req_i.count;
          wr_last = (req_i.count == CNT_W'(1));
          sp_d    = sp_q + DEPTH_W'(1);
        end
      end
      NEST_CLEAR: begin
        sp_d = '0;
      end
      default: begin
        sp_d = sp_q;
      end
    endcase
    // Closing levels pops everything above the surviving one.
    if (do_complete) begin
      if (!found) begin
        sp_d          = '0;
        rsp_o.top_end = 1'b1;
      end else begin
        wr_en = 1'b1;
        sp_d  = DEPTH_W'(top_idx) + DEPTH_W'(1);
      end
    end
    rsp_o.depth_next = sp_d;
  end

  // Count storage, written at most once per step.
  always_ff @(posedge clk_i) begin
    if (step_i && wr_en) begin
      cnt_q[wr_idx] <= wr_val;
    end
  end

  // Stack pointer and last-element bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q   <= '0;
      last_q <= '0;
    end else if (step_i) begin
      sp_q <= sp_d;
      if (wr_en) begin
        last_q[wr_idx] <= wr_last;
      end
    end
  end

endmodule
